@@ rtl/vbts_pkg.sv @@
// ----------------------------------------------------------------------------
// vbts_pkg
// Shared types and constants for the volatility band trade signal block.
// ----------------------------------------------------------------------------
package vbts_pkg;

  // Default window length of the sample ring
  localparam int WINDOW_DEF = 30;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int LIQ_W      = 32;
  localparam int COST_W     = 23;
  localparam int GAIN_W     = 32;
  localparam int SIZE_W     = 31;
  localparam int SCALE_W    = 16;
  localparam int ACTION_W   = 2;
  localparam int MUL_W      = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TRADE_COST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_COST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIQUIDITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SCALE = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]  SIZE_GAIN_RST       = 32'd65536;
  localparam logic [SIZE_W-1:0]  SIZE_LIMIT_RST      = 31'h7FFF_FFFF;
  localparam logic [SCALE_W-1:0] THRESHOLD_SCALE_RST = 16'd655;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_HOLD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BUY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SELL = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] diff_sample;
    logic signed [SAMPLE_W-1:0] trend_value;
    logic        [LIQ_W-1:0]    available_liquidity;
  } in_item_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action_code;
    logic [SIZE_W-1:0]   position_amount;
  } out_item_t;

  typedef struct packed {
    logic [COST_W-1:0]  trade_cost;
    logic [COST_W-1:0]  delay_cost;
    logic [LIQ_W-1:0]   min_liquidity;
    logic [GAIN_W-1:0]  size_gain;
    logic [SIZE_W-1:0]  size_limit;
    logic [SCALE_W-1:0] threshold_scale;
  } cfg_t;

endpackage

@@ rtl/vbts_cfg.sv @@
// ----------------------------------------------------------------------------
// vbts_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module vbts_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [vbts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output vbts_pkg::cfg_t             cfg_o
);
  import vbts_pkg::*;

  cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trade_cost      <= '0;
      cfg_r.delay_cost      <= '0;
      cfg_r.min_liquidity   <= '0;
      cfg_r.size_gain       <= SIZE_GAIN_RST;
      cfg_r.size_limit      <= SIZE_LIMIT_RST;
      cfg_r.threshold_scale <= THRESHOLD_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRADE_COST:      cfg_r.trade_cost      <= cfg_wdata[COST_W-1:0];
        CFG_DELAY_COST:      cfg_r.delay_cost      <= cfg_wdata[COST_W-1:0];
        CFG_MIN_LIQUIDITY:   cfg_r.min_liquidity   <= cfg_wdata[LIQ_W-1:0];
        CFG_SIZE_GAIN:       cfg_r.size_gain       <= cfg_wdata[GAIN_W-1:0];
        CFG_SIZE_LIMIT:      cfg_r.size_limit      <= cfg_wdata[SIZE_W-1:0];
        CFG_THRESHOLD_SCALE: cfg_r.threshold_scale <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ rtl/vbts_ring.sv @@
// ----------------------------------------------------------------------------
// vbts_ring
// Sample ring memory with write pointer; entries not yet written read as zero.
// ----------------------------------------------------------------------------
module vbts_ring #(
  parameter int WINDOW = vbts_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_en,
  input  logic                                wr_en,
  input  logic signed [vbts_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [vbts_pkg::SAMPLE_W-1:0] rd_data
);
  import vbts_pkg::*;

  localparam int AW = $clog2(WINDOW);

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]          vld_r;
  logic [AW-1:0]              wp_r;
  logic signed [SAMPLE_W-1:0] rdat_r;
  logic                       rvld_r;

  // Storage: synchronous write, registered read at the pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem[wp_r];
    end
  end

  // Entry valid bits, pointer and read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      wp_r   <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rvld_r <= vld_r[wp_r];
      end
      if (wr_en) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
      end
    end
  end

  assign rd_data = rvld_r ? rdat_r : '0;

endmodule

@@ rtl/vbts_mul.sv @@
// ----------------------------------------------------------------------------
// vbts_mul
// Shared unsigned 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module vbts_mul (
  input  logic                           clk,
  input  logic [vbts_pkg::MUL_W-1:0]     op_a,
  input  logic [vbts_pkg::MUL_W-1:0]     op_b,
  output logic [2*vbts_pkg::MUL_W-1:0]   prod
);
  import vbts_pkg::*;

  logic [2*MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ rtl/volatility_band_trade_signal.sv @@
// ----------------------------------------------------------------------------
// volatility_band_trade_signal
// Rolling volatility band test on a price difference stream, giving a
// buy / sell / hold decision with a saturated position size.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) takes one sample item per
//   transfer. Result channel (out_valid / out_ready / out_data) gives exactly
//   one result per item, in order. Configuration is a plain write port
//   (cfg_we, cfg_index, cfg_wdata), written while the block is idle.
//   in_ready rises at the same edge as out_valid, so the block takes no new
//   item until it is through with the last one. The steps are set by the
//   single shared 32x32 multiplier, which runs the seven products of an item
//   one after another, plus the sample ring read and the wide sum updates.
//   The result sits in an output register, so a new item is taken while an
//   earlier result still waits; if the receiver stalls, the following item
//   waits in its final step until the output register is free.
//   Synchronous reset clears the ring (per-entry valid bits, so no clearing
//   pass), the pointer, the running sums and loads the register defaults.
// ----------------------------------------------------------------------------
module volatility_band_trade_signal #(
  parameter int WINDOW = vbts_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vbts_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vbts_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [vbts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vbts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import vbts_pkg::*;

  // Derived widths
  localparam int S1W  = SAMPLE_W + $clog2(WINDOW);
  localparam int SQW  = 2 * SAMPLE_W;
  localparam int S2W  = SQW - 2 + $clog2(WINDOW + 1);
  localparam int VW   = S2W + $clog2(WINDOW + 1);
  localparam int W2   = WINDOW * WINDOW;
  localparam int AW_A = SQW + $clog2(W2 + 1);
  localparam int CW   = (AW_A > VW) ? AW_A : VW;
  localparam int PW   = 2 * MUL_W;
  localparam int FSW  = SAMPLE_W + GAIN_W - 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_SQOLD, ST_S1SQ, ST_SCALE,
    ST_VAR, ST_VLO, ST_VHI, ST_SIZE, ST_DEC
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;

  cfg_t      cfg;
  in_item_t  item_r;

  logic signed [SAMPLE_W-1:0] old_smp;
  logic signed [S1W-1:0]      s1_r;
  logic [S2W-1:0]             s2sum_r;
  logic [SQW-1:0]             sq_new_r;
  logic [PW-1:0]              s1sq_r;
  logic [VW-1:0]              ws2_r;
  logic [VW-1:0]              v_r;
  logic [MUL_W-1:0]           scl2_r;
  logic [AW_A-1:0]            a_r;
  logic [PW-1:0]              lo_r;
  logic [VW-1:0]              bhi_r;

  logic [MUL_W-1:0]           op_a, op_b;
  logic [PW-1:0]              prod;

  logic [SAMPLE_W-1:0]        mag, old_mag;
  logic [S1W-1:0]             s1_mag;
  logic                       accept, out_free;
  logic                       band, profitable, is_buy, is_sell;
  logic [SAMPLE_W-1:0]        cost_sum;
  logic [FSW-1:0]             size_full;
  logic [SIZE_W-1:0]          size_sat;
  out_item_t                  result;

  // Sub-blocks
  vbts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  vbts_ring #(.WINDOW(WINDOW)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .wr_en   (state_r == ST_READ),
    .wr_data (item_r.diff_sample),
    .rd_data (old_smp)
  );

  vbts_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Magnitudes
  assign mag     = item_r.diff_sample[SAMPLE_W-1] ? SAMPLE_W'(-item_r.diff_sample)
                                                  : SAMPLE_W'(item_r.diff_sample);
  assign old_mag = old_smp[SAMPLE_W-1] ? SAMPLE_W'(-old_smp) : SAMPLE_W'(old_smp);
  assign s1_mag  = s1_r[S1W-1] ? S1W'(-s1_r) : S1W'(s1_r);

  // Multiplier operand selection per step
  always_comb begin
    op_a = MUL_W'(mag);
    op_b = MUL_W'(mag);
    unique case (state_r)
      ST_SQOLD: begin
        op_a = MUL_W'(old_mag);
        op_b = MUL_W'(old_mag);
      end
      ST_S1SQ: begin
        op_a = MUL_W'(s1_mag);
        op_b = MUL_W'(s1_mag);
      end
      ST_SCALE: begin
        op_a = MUL_W'(cfg.threshold_scale);
        op_b = MUL_W'(cfg.threshold_scale);
      end
      ST_VLO: begin
        op_a = scl2_r;
        op_b = v_r[MUL_W-1:0];
      end
      ST_VHI: begin
        op_a = scl2_r;
        op_b = MUL_W'(v_r[VW-1:MUL_W]);
      end
      ST_SIZE, ST_DEC: begin
        op_a = MUL_W'(mag);
        op_b = cfg.size_gain;
      end
      default: ;
    endcase
  end

  // Decision logic for the final step
  assign cost_sum   = SAMPLE_W'(cfg.trade_cost) + SAMPLE_W'(cfg.delay_cost);
  assign profitable = (mag > cost_sum) &&
                      (item_r.available_liquidity >= cfg.min_liquidity);
  assign band       = CW'(a_r) > CW'(bhi_r);
  assign is_buy     = profitable && band &&
                      !item_r.diff_sample[SAMPLE_W-1] && (item_r.diff_sample != '0) &&
                      !item_r.trend_value[SAMPLE_W-1] && (item_r.trend_value != '0);
  assign is_sell    = profitable && band &&
                      item_r.diff_sample[SAMPLE_W-1] && item_r.trend_value[SAMPLE_W-1];
  assign size_full  = prod[SAMPLE_W+GAIN_W-1:16];
  assign size_sat   = (size_full > FSW'(cfg.size_limit)) ? cfg.size_limit
                                                         : size_full[SIZE_W-1:0];

  always_comb begin
    result.action_code     = ACT_HOLD;
    result.position_amount = '0;
    if (is_buy) begin
      result.action_code     = ACT_BUY;
      result.position_amount = size_sat;
    end else if (is_sell) begin
      result.action_code     = ACT_SELL;
      result.position_amount = size_sat;
    end
  end

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_SQOLD;
      ST_SQOLD: state_nxt = ST_S1SQ;
      ST_S1SQ:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_VAR;
      ST_VAR:   state_nxt = ST_VLO;
      ST_VLO:   state_nxt = ST_VHI;
      ST_VHI:   state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_DEC;
      ST_DEC:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State, running statistics and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      s1_r        <= '0;
      s2sum_r     <= '0;
    end else begin
      state_r <= state_nxt;
      // load a new result, or drop the old one once it is taken
      if (state_r == ST_DEC && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // sum update: new sample in, oldest out
      if (state_r == ST_READ) begin
        s1_r <= s1_r + S1W'(item_r.diff_sample) - S1W'(old_smp);
      end
      if (state_r == ST_S1SQ) begin
        s2sum_r <= s2sum_r + S2W'(sq_new_r) - S2W'(prod[SQW-1:0]);
      end
    end
  end

  // Working registers of one item
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    case (state_r)
      ST_SQOLD: sq_new_r <= prod[SQW-1:0];
      ST_SCALE: begin
        s1sq_r <= prod;
        ws2_r  <= VW'(s2sum_r) * VW'(WINDOW);
      end
      ST_VAR: begin
        scl2_r <= prod[MUL_W-1:0];
        v_r    <= (ws2_r >= VW'(s1sq_r)) ? ws2_r - VW'(s1sq_r) : '0;
        a_r    <= AW_A'(sq_new_r) * AW_A'(W2);
      end
      ST_VHI:  lo_r  <= prod;
      ST_SIZE: bhi_r <= VW'(prod) + VW'(lo_r[PW-1:MUL_W]);
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/volatility_band_trade_signal_tb.sv @@
// ----------------------------------------------------------------------------
// volatility_band_trade_signal_tb
// Self-checking bench for the volatility band trade signal block. A clocked
// driver feeds sample items from a queue and a clocked monitor takes the
// results. Both sides idle at random. Every accepted item runs through a
// local predictor that keeps its own sample ring and running sums. The
// predicted action and size are compared, field by field, with the results
// in order. The run covers a directed set of corner cases, then random
// phases under several register settings, including the extremes.
// ----------------------------------------------------------------------------
module volatility_band_trade_signal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vbts_pkg::*;

  localparam int          WIN            = WINDOW_DEF;
  localparam int          PHASE_ITEMS    = 240;
  localparam int          PHASE_COUNT    = 6;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int          MAX_REPORTS    = 200;
  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  logic [COST_W-1:0]  m_trade_cost = '0;
  logic [COST_W-1:0]  m_delay_cost = '0;
  logic [LIQ_W-1:0]   m_min_liq    = '0;
  logic [GAIN_W-1:0]  m_size_gain  = SIZE_GAIN_RST;
  logic [SIZE_W-1:0]  m_size_limit = SIZE_LIMIT_RST;
  logic [SCALE_W-1:0] m_scale      = THRESHOLD_SCALE_RST;

  // predictor copy of the window statistics
  longint ring_hist [WIN];
  int     ring_pos   = 0;
  longint run_sum    = 0;
  longint run_sq_sum = 0;

  in_item_t    pending_samples [$];
  out_item_t   expected_signals [$];
  int          mismatch_count = 0;
  int          result_index   = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_wait      = 0;
  int unsigned stall_left     = 0;
  bit          send_idle      = 1'b1;
  bit          recv_idle      = 1'b1;
  int unsigned quiet_width    = 8;
  out_item_t   want;

  volatility_band_trade_signal DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Trade decision for one sample, after it has entered the window
  function automatic out_item_t predict_signal(in_item_t it);
    longint     d, trend, oldest, s1_mag;
    bit [63:0]  mag, s1_sq, w_s2, spread, scale_sq, lhs, size_raw;
    bit [127:0] rhs;
    bit         worth_it, above;
    out_item_t  res;
    d      = longint'($signed(it.diff_sample));
    trend  = longint'($signed(it.trend_value));
    oldest = ring_hist[ring_pos];
    ring_hist[ring_pos] = d;
    run_sum    += d - oldest;
    run_sq_sum += d * d - oldest * oldest;
    ring_pos = (ring_pos == WIN - 1) ? 0 : ring_pos + 1;

    // band test without a root: d^2 * W^2 * 2^32 > scale^2 * (W*S2 - S1^2)
    mag      = (d < 0) ? -d : d;
    s1_mag   = (run_sum < 0) ? -run_sum : run_sum;
    s1_sq    = s1_mag * s1_mag;
    w_s2     = WIN * run_sq_sum;
    spread   = (w_s2 >= s1_sq) ? w_s2 - s1_sq : 64'd0;
    scale_sq = 64'(m_scale) * 64'(m_scale);
    rhs      = 128'(scale_sq) * 128'(spread);
    lhs      = mag * mag * WIN * WIN;
    above    = lhs > rhs[95:32];

    worth_it = (mag > 64'(m_trade_cost) + 64'(m_delay_cost)) &&
               (it.available_liquidity >= m_min_liq);

    res.action_code     = ACT_HOLD;
    res.position_amount = '0;
    if (worth_it && above && d > 0 && trend > 0) begin
      res.action_code = ACT_BUY;
    end else if (worth_it && above && d < 0 && trend < 0) begin
      res.action_code = ACT_SELL;
    end
    if (res.action_code != ACT_HOLD) begin
      size_raw = (mag * 64'(m_size_gain)) >> 16;
      res.position_amount = (size_raw > 64'(m_size_limit)) ? m_size_limit
                                                           : size_raw[SIZE_W-1:0];
    end
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TRADE_COST:      m_trade_cost = data[COST_W-1:0];
      CFG_DELAY_COST:      m_delay_cost = data[COST_W-1:0];
      CFG_MIN_LIQUIDITY:   m_min_liq    = data[LIQ_W-1:0];
      CFG_SIZE_GAIN:       m_size_gain  = data[GAIN_W-1:0];
      CFG_SIZE_LIMIT:      m_size_limit = data[SIZE_W-1:0];
      CFG_THRESHOLD_SCALE: m_scale      = data[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(99);
    if (!enabled || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Random garbage above a register's width
  function automatic logic [CFG_DATA_W-1:0] junk_above(int width, logic [CFG_DATA_W-1:0] v);
    return (32'($urandom) << width) | v;
  endfunction

  function automatic in_item_t sample_of(logic [SAMPLE_W-1:0] d, logic [SAMPLE_W-1:0] t,
                                         logic [LIQ_W-1:0] l);
    in_item_t it;
    it.diff_sample         = d;
    it.trend_value         = t;
    it.available_liquidity = l;
    return it;
  endfunction

  // Quiet stretches of small samples with spikes, trend mostly agreeing
  function automatic in_item_t random_item(int unsigned qw);
    in_item_t                   it;
    int unsigned                pick;
    logic [SAMPLE_W-1:0]        mag;
    logic signed [SAMPLE_W-1:0] d, t;
    logic [LIQ_W-1:0]           liq;
    pick = $urandom_range(99);
    if (pick < 55) begin
      mag = SAMPLE_W'($urandom_range((1 << qw) - 1));
      d = $urandom_range(1) ? -$signed(mag) : $signed(mag);
    end else if (pick < 80) begin
      d = SAMPLE_W'($urandom);
    end else if (pick < 90) begin
      mag = SAMPLE_W'(24'h7FFFFF - $urandom_range(24'hFFFF));
      d = $urandom_range(1) ? -$signed(mag) : $signed(mag);
    end else if (pick < 94) begin
      d = '0;
    end else begin
      case ($urandom_range(3))
        0:       d = 24'h7FFFFF;
        1:       d = 24'h800000;
        2:       d = 24'sd1;
        default: d = -24'sd1;
      endcase
    end

    pick = $urandom_range(99);
    if (pick < 70) begin
      t = SAMPLE_W'($urandom_range(24'h7FFFFF, 1));
      if (d < 0) t = -t;
      else if (d == 0) t = SAMPLE_W'($urandom);
    end else if (pick < 80) begin
      t = '0;
    end else begin
      t = SAMPLE_W'($urandom);
    end

    pick = $urandom_range(99);
    if (pick < 50) liq = $urandom;
    else if (pick < 75) liq = m_min_liq + $urandom_range(2);
    else if (pick < 85) liq = m_min_liq - 1;
    else liq = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;

    it.diff_sample         = d;
    it.trend_value         = t;
    it.available_liquidity = liq;
    return it;
  endfunction

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
               what, result_index, exp_v, got_v);
  endtask

  // One register write, captured at the next edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic load_settings(logic [31:0] tc, logic [31:0] dc, logic [31:0] ml,
                               logic [31:0] sg, logic [31:0] sl, logic [31:0] ts,
                               bit spare);
    write_reg(CFG_TRADE_COST,      junk_above(COST_W, tc));
    write_reg(CFG_DELAY_COST,      junk_above(COST_W, dc));
    write_reg(CFG_MIN_LIQUIDITY,   ml);
    write_reg(CFG_SIZE_GAIN,       sg);
    write_reg(CFG_SIZE_LIMIT,      junk_above(SIZE_W, sl));
    write_reg(CFG_THRESHOLD_SCALE, junk_above(SCALE_W, ts));
    if (spare) begin
      write_reg(CFG_SPARE_LO, $urandom);
      write_reg(CFG_SPARE_HI, $urandom);
    end
    cfg_we <= 1'b0;
  endtask

  // Registers, sample amplitude and idling for one random phase
  task automatic configure_phase(int ph);
    bit spare;
    spare = $urandom_range(1);
    case (ph)
      0: load_settings(0, 0, 0, 32'd65536, 32'h7FFF_FFFF, 655, spare);
      1: load_settings(32'h7FFFFF, 32'h7FFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'hFFFF,
                       spare);
      2: load_settings($urandom_range(32'h3FFF), $urandom_range(32'h3FFF),
                       $urandom_range(32'h0FFF_FFFF), $urandom,
                       $urandom_range(32'h000F_FFFF), 0, spare);
      3: load_settings($urandom_range(32'h7FFF), $urandom_range(32'h7FFF), $urandom,
                       $urandom, $urandom_range(32'h7FFF_FFFF), $urandom_range(16'hFFFF),
                       spare);
      4: load_settings(0, 0, 0, $urandom, 32'h7FFF_FFFF, 16'hFFFF, spare);
      default: load_settings($urandom_range(32'h1FFFF), $urandom_range(32'h1FFFF),
                             $urandom, 0, $urandom_range(32'h7FFF_FFFF),
                             $urandom_range(4000), spare);
    endcase
    @(negedge clk);
    case (ph)
      0: begin quiet_width = 8;  send_idle = 1'b0; recv_idle = 1'b0; end
      1: begin quiet_width = 20; send_idle = 1'b1; recv_idle = 1'b1; end
      2: begin quiet_width = 12; send_idle = 1'b1; recv_idle = 1'b0; end
      3: begin quiet_width = 16; send_idle = 1'b0; recv_idle = 1'b1; end
      4: begin quiet_width = 10; send_idle = 1'b1; recv_idle = 1'b1; end
      default: begin quiet_width = 14; send_idle = 1'b1; recv_idle = 1'b1; end
    endcase
  endtask

  // Block until every item is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_signals.size() != 0);
    @(posedge clk);
  endtask

  // Input driver: takes the next pending item once the previous transfer is done
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready)
        expected_signals.push_back(predict_signal(in_data));
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_data   <= pending_samples.pop_front();
          in_valid  <= 1'b1;
          send_wait = idle_gap(send_idle);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_signals.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'(out_data));
        end else begin
          want = expected_signals.pop_front();
          if (out_data.action_code !== want.action_code)
            report_mismatch("action_code", 64'(want.action_code),
                            64'(out_data.action_code));
          if (out_data.position_amount !== want.position_amount)
            report_mismatch("position_amount", 64'(want.position_amount),
                            64'(out_data.position_amount));
        end
        result_index++;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = idle_gap(recv_idle);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int ph;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases at the reset settings, window still all zero
    @(negedge clk);
    pending_samples.push_back(sample_of(24'h000000, 24'h100000, 32'hFFFF_FFFF));
    pending_samples.push_back(sample_of(24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF));
    pending_samples.push_back(sample_of(24'h800000, 24'h800000, 32'h0000_0000));
    pending_samples.push_back(sample_of(24'h400000, 24'h000000, 32'h0000_0001));
    pending_samples.push_back(sample_of(24'h400000, 24'hFFFFFF, 32'h1234_5678));
    pending_samples.push_back(sample_of(24'hC00000, 24'h000001, 32'h8000_0000));
    pending_samples.push_back(sample_of(24'h000001, 24'h000001, 32'h0000_0000));
    pending_samples.push_back(sample_of(24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_samples.push_back(sample_of(24'h000100, 24'h000100, 32'h0000_FFFF));
    pending_samples.push_back(sample_of(24'h7FFFFF, 24'h000001, 32'hFFFF_0000));
    pending_samples.push_back(sample_of(24'h800000, 24'h7FFFFF, 32'h7FFF_FFFF));
    pending_samples.push_back(sample_of(24'h555555, 24'h2AAAAA, 32'hAAAA_AAAA));
    pending_samples.push_back(sample_of(24'hAAAAAA, 24'hD55555, 32'h5555_5555));
    wait_drained();

    // zero scale, costs on the edge, liquidity on the edge, size saturation
    load_settings(32'h010000, 32'h008000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1000, 0, 1'b1);
    @(negedge clk);
    pending_samples.push_back(sample_of(24'h018000, 24'h000001, 32'h8000_0000));
    pending_samples.push_back(sample_of(24'h018001, 24'h000001, 32'h8000_0000));
    pending_samples.push_back(sample_of(24'h018001, 24'h000001, 32'h7FFF_FFFF));
    pending_samples.push_back(sample_of(24'hFE7FFF, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_samples.push_back(sample_of(24'h000000, 24'h800000, 32'hFFFF_FFFF));
    pending_samples.push_back(sample_of(24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF));
    pending_samples.push_back(sample_of(24'h800000, 24'h800000, 32'hFFFF_FFFF));

    // random phases, one register setting each
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      configure_phase(ph);
      repeat (PHASE_ITEMS) pending_samples.push_back(random_item(quiet_width));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
